@@ rtl/redundant_rhythm_shock_controller_defines.svh @@
// Assertion macros shared by the rhythm shock controller modules.
`ifndef REDUNDANT_RHYTHM_SHOCK_CONTROLLER_DEFINES_SVH
`define REDUNDANT_RHYTHM_SHOCK_CONTROLLER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RRSC_ASSERT_SAME(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define RRSC_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// Check that a condition never holds.
`define RRSC_ASSERT_NEVER(lbl, ck, rn, bad, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(bad)) \
    else $error(msg);

`endif

@@ rtl/rrsc_pkg.sv @@
// Types and constants of the rhythm shock controller.
`timescale 1ns / 1ps

package rrsc_pkg;

  localparam int SENSOR_COUNT = 3;
  localparam int LEVEL_W      = 2;
  localparam int WORK_W       = SENSOR_COUNT;
  localparam int RATE_W       = 16;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int INTERVAL_W   = 10;
  localparam int BAND_W       = 8;
  localparam int TICK_W       = 16;
  localparam int RUN_W        = 8;
  localparam int UDRUN_W      = 2;

  // One quotient bit per divide step.
  localparam int DIV_STEPS = RATE_W;

  localparam logic [RATE_W-1:0] MS_PER_MINUTE = 16'd60000;

  // Level codes
  localparam logic [LEVEL_W-1:0] LVL_REST = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_UP   = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_LOW  = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_BAD  = 2'd3;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_MON   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ARMED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PEND  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MAX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LIMIT = 3'd7;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] RST_INTERVAL   = 10'd400;
  localparam logic [BAND_W-1:0]     RST_LOW_MIN    = 8'd40;
  localparam logic [BAND_W-1:0]     RST_LOW_MAX    = 8'd49;
  localparam logic [BAND_W-1:0]     RST_FAST_MIN   = 8'd90;
  localparam logic [BAND_W-1:0]     RST_FAST_MAX   = 8'd99;
  localparam logic [TICK_W-1:0]     RST_WAIT       = 16'd750;
  localparam logic [TICK_W-1:0]     RST_LOCKOUT    = 16'd25;
  localparam logic [RUN_W-1:0]      RST_REST_LIMIT = 8'd25;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic mul_load;
    logic div_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

endpackage

@@ rtl/rrsc_if.sv @@
// Channel interfaces: sample input, result output and register write.
`timescale 1ns / 1ps

interface rrsc_in_if;
  import rrsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] sensor_a_level;
  logic [LEVEL_W-1:0] sensor_b_level;
  logic [LEVEL_W-1:0] sensor_c_level;
  logic [WORK_W-1:0]  sensor_working;

  modport source (output valid, sensor_a_level, sensor_b_level, sensor_c_level,
                  sensor_working, input ready);
  modport sink (input valid, sensor_a_level, sensor_b_level, sensor_c_level,
                sensor_working, output ready);
endinterface

interface rrsc_out_if;
  import rrsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] voted_level;
  logic [RATE_W-1:0]  beat_rate;
  logic               rate_updated;
  logic               shock;
  logic [MODE_W-1:0]  mode;

  modport source (output valid, voted_level, beat_rate, rate_updated, shock, mode,
                  input ready);
  modport sink (input valid, voted_level, beat_rate, rate_updated, shock, mode,
                output ready);
endinterface

interface rrsc_cfg_if;
  import rrsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/rrsc_ctrl.sv @@
// Sequencer of the rhythm shock controller: capture, divide, commit.
`timescale 1ns / 1ps
`include "redundant_rhythm_shock_controller_defines.svh"

module rrsc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rrsc_pkg::status_t status,
  output rrsc_pkg::cmd_t    cmd
);
  import rrsc_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              step_last;

  assign step_last = (step_r == STEP_W'(DIV_STEPS - 1));

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        if (status.need_div) begin
          cmd.mul_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

  // State and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `RRSC_ASSERT_SAME(a_commit_free, clk, rst_n, cmd.commit, status.out_free, "commit into a full output register")
  `RRSC_ASSERT_NEXT(a_div_len, clk, rst_n, state_r == S_DIV && step_last, state_r == S_FIN, "divide did not end in finish")
  `RRSC_ASSERT_NEXT(a_fin_hold, clk, rst_n, state_r == S_FIN && !status.out_free, state_r == S_FIN, "finish left while output stalled")
  `RRSC_ASSERT_SAME(a_step_rest, clk, rst_n, state_r != S_DIV, step_r == '0, "step counter not at zero outside divide")

endmodule

@@ rtl/rrsc_dp.sv @@
// Datapath of the rhythm shock controller: vote, counters, divider, timers.
`timescale 1ns / 1ps
`include "redundant_rhythm_shock_controller_defines.svh"

module rrsc_dp #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rrsc_pkg::cmd_t                     cmd,
  output rrsc_pkg::status_t                  status,
  input  logic [rrsc_pkg::LEVEL_W-1:0]       sensor_a_level,
  input  logic [rrsc_pkg::LEVEL_W-1:0]       sensor_b_level,
  input  logic [rrsc_pkg::LEVEL_W-1:0]       sensor_c_level,
  input  logic [rrsc_pkg::WORK_W-1:0]        sensor_working,
  input  logic                               cfg_write,
  input  logic [rrsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [rrsc_pkg::LEVEL_W-1:0]       voted_level,
  output logic [rrsc_pkg::RATE_W-1:0]        beat_rate,
  output logic                               rate_updated,
  output logic                               shock,
  output logic [rrsc_pkg::MODE_W-1:0]        mode
);
  import rrsc_pkg::*;

  localparam int PROD_W = INTERVAL_W + COUNT_WIDTH;
  localparam int REM_W  = DIV_STEPS + 1;

  // Configuration registers
  logic [INTERVAL_W-1:0] interval_r;
  logic [BAND_W-1:0]     low_min_r, low_max_r, fast_min_r, fast_max_r;
  logic [TICK_W-1:0]     wait_ticks_r, lockout_ticks_r;
  logic [RUN_W-1:0]      rest_limit_r;

  // Captured sample
  logic [LEVEL_W-1:0] lvls_r [SENSOR_COUNT];
  logic [WORK_W-1:0]  work_r;

  // Tick state
  logic [LEVEL_W-1:0]     prev_r, prev_nxt;
  logic [COUNT_WIDTH-1:0] pulse_r, pulse_nxt;
  logic [RUN_W-1:0]       rest_r, rest_nxt;
  logic [UDRUN_W-1:0]     upper_r, upper_nxt, lower_r, lower_nxt;
  logic                   started_r, started_nxt;
  logic [RATE_W-1:0]      rate_r, rate_nxt;
  logic [TICK_W-1:0]      wait_r, wait_nxt, lock_r, lock_nxt;
  logic                   armed_r, armed_nxt, pend_r, pend_nxt;

  // Divider
  logic [PROD_W-1:0]  prod_full, prod_r;
  logic [RATE_W-1:0]  num_r, rem_r, quo_r;
  logic [REM_W-1:0]   rem_sh, rem_sub;
  logic               d_big, ge;

  // Output register
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [RATE_W-1:0]  out_rate_r;
  logic               out_upd_r, out_shock_r;
  logic [MODE_W-1:0]  out_mode_r;

  // Tick evaluation
  logic [1:0]         t_rest, t_up, t_low;
  logic [LEVEL_W-1:0] lv;
  logic               rep, request, arm, updated, armed_now, fire;
  logic               armed_a, pend_a, pend_b;
  logic [TICK_W-1:0]  wait_a;
  logic [MODE_W-1:0]  mode_nxt;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r      <= RST_INTERVAL;
      low_min_r       <= RST_LOW_MIN;
      low_max_r       <= RST_LOW_MAX;
      fast_min_r      <= RST_FAST_MIN;
      fast_max_r      <= RST_FAST_MAX;
      wait_ticks_r    <= RST_WAIT;
      lockout_ticks_r <= RST_LOCKOUT;
      rest_limit_r    <= RST_REST_LIMIT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_INTERVAL:   interval_r      <= cfg_data[INTERVAL_W-1:0];
        REG_LOW_MIN:    low_min_r       <= cfg_data[BAND_W-1:0];
        REG_LOW_MAX:    low_max_r       <= cfg_data[BAND_W-1:0];
        REG_FAST_MIN:   fast_min_r      <= cfg_data[BAND_W-1:0];
        REG_FAST_MAX:   fast_max_r      <= cfg_data[BAND_W-1:0];
        REG_WAIT:       wait_ticks_r    <= cfg_data[TICK_W-1:0];
        REG_LOCKOUT:    lockout_ticks_r <= cfg_data[TICK_W-1:0];
        REG_REST_LIMIT: rest_limit_r    <= cfg_data[RUN_W-1:0];
      endcase
    end
  end

  // Hold the accepted sample
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lvls_r[0] <= sensor_a_level;
      lvls_r[1] <= sensor_b_level;
      lvls_r[2] <= sensor_c_level;
      work_r    <= sensor_working;
    end
  end

  // Tally working sensors; a level code of three casts no vote
  always_comb begin
    t_rest = '0;
    t_up   = '0;
    t_low  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      t_rest = t_rest + 2'(work_r[i] && lvls_r[i] == LVL_REST);
      t_up   = t_up   + 2'(work_r[i] && lvls_r[i] == LVL_UP);
      t_low  = t_low  + 2'(work_r[i] && lvls_r[i] == LVL_LOW);
    end
  end

  // Most votes wins, ties favor resting, then upper
  always_comb begin
    priority if (t_low > t_rest && t_low > t_up) begin
      lv = LVL_LOW;
    end else if (t_up > t_rest) begin
      lv = LVL_UP;
    end else begin
      lv = LVL_REST;
    end
  end

  assign rep = (lv == prev_r) && (lv != LVL_REST);

  assign status.need_div = !rep && (lv == LVL_UP) && (upper_r < 2'd2) && started_r;
  assign status.out_free = !out_valid_r || out_ready;

  // Divisor is interval times pulse count, zero taken as one
  assign prod_full = PROD_W'(interval_r) * PROD_W'(pulse_r);

  // Restoring divide step; remainder never exceeds the 16-bit dividend
  assign rem_sh  = {rem_r, num_r[RATE_W-1]};
  assign d_big   = |prod_r[PROD_W-1:REM_W];
  assign ge      = !d_big && (rem_sh >= prod_r[REM_W-1:0]);
  assign rem_sub = ge ? (rem_sh - prod_r[REM_W-1:0]) : rem_sh;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= (prod_full == '0) ? PROD_W'(1) : prod_full;
      num_r  <= MS_PER_MINUTE;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[RATE_W-2:0], 1'b0};
      rem_r <= rem_sub[RATE_W-1:0];
      quo_r <= {quo_r[RATE_W-2:0], ge};
    end
  end

  // Run counters, rate bands, arming, wait and lockout timers
  always_comb begin
    prev_nxt    = lv;
    pulse_nxt   = pulse_r;
    rest_nxt    = rest_r;
    upper_nxt   = upper_r;
    lower_nxt   = lower_r;
    started_nxt = started_r;
    rate_nxt    = rate_r;
    request     = 1'b0;
    arm         = 1'b0;
    updated     = 1'b0;
    if (!rep) begin
      priority if (lv == LVL_REST) begin
        if (rest_r > rest_limit_r) begin
          request = 1'b1;
        end
        if (rest_r != '1) begin
          rest_nxt = rest_r + RUN_W'(1);
        end
        if (pulse_r != '1) begin
          pulse_nxt = pulse_r + COUNT_WIDTH'(1);
        end
      end else if (lv == LVL_UP) begin
        lower_nxt = '0;
        rest_nxt  = '0;
        if (upper_r >= 2'd2) begin
          request = 1'b1;
        end else if (started_r) begin
          rate_nxt = quo_r;
          updated  = 1'b1;
          if ((quo_r >= RATE_W'(low_min_r) && quo_r <= RATE_W'(low_max_r)) ||
              (quo_r >= RATE_W'(fast_min_r) && quo_r <= RATE_W'(fast_max_r))) begin
            arm = 1'b1;
          end else if (quo_r < RATE_W'(low_max_r) || quo_r > RATE_W'(fast_max_r)) begin
            request = 1'b1;
          end
        end
        if (upper_r != '1) begin
          upper_nxt = upper_r + UDRUN_W'(1);
        end
        pulse_nxt   = '0;
        started_nxt = 1'b1;
      end else begin
        if (pulse_r != '1) begin
          pulse_nxt = pulse_r + COUNT_WIDTH'(1);
        end
        upper_nxt = '0;
        rest_nxt  = '0;
        if (lower_r >= 2'd2) begin
          request = 1'b1;
        end
        if (lower_r != '1) begin
          lower_nxt = lower_r + UDRUN_W'(1);
        end
      end
    end

    // Request wins over arming; arming is ignored while a shock waits
    armed_a   = armed_r;
    pend_a    = pend_r;
    wait_a    = wait_r;
    armed_now = 1'b0;
    if (request) begin
      pend_a  = 1'b1;
      armed_a = 1'b0;
    end else if (arm && !pend_r) begin
      armed_a   = 1'b1;
      wait_a    = (wait_ticks_r == '0) ? TICK_W'(1) : wait_ticks_r;
      armed_now = 1'b1;
    end

    // Count down an earlier arming
    armed_nxt = armed_a;
    pend_b    = pend_a;
    wait_nxt  = wait_a;
    if (armed_a && !armed_now) begin
      if (wait_a <= TICK_W'(1)) begin
        wait_nxt  = '0;
        armed_nxt = 1'b0;
        pend_b    = 1'b1;
      end else begin
        wait_nxt = wait_a - TICK_W'(1);
      end
    end

    // Deliver outside the lockout
    fire     = 1'b0;
    pend_nxt = pend_b;
    lock_nxt = lock_r;
    if (pend_b && lock_r == '0) begin
      fire     = 1'b1;
      pend_nxt = 1'b0;
      lock_nxt = lockout_ticks_r;
    end else if (lock_r != '0) begin
      lock_nxt = lock_r - TICK_W'(1);
    end

    if (pend_nxt) begin
      mode_nxt = MODE_PEND;
    end else if (armed_nxt) begin
      mode_nxt = MODE_ARMED;
    end else begin
      mode_nxt = MODE_MON;
    end
  end

  // Advance tick state on commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= LVL_REST;
      pulse_r   <= '0;
      rest_r    <= '0;
      upper_r   <= '0;
      lower_r   <= '0;
      started_r <= 1'b0;
      rate_r    <= '0;
      wait_r    <= '0;
      armed_r   <= 1'b0;
      pend_r    <= 1'b0;
      lock_r    <= '0;
    end else if (cmd.commit) begin
      prev_r    <= prev_nxt;
      pulse_r   <= pulse_nxt;
      rest_r    <= rest_nxt;
      upper_r   <= upper_nxt;
      lower_r   <= lower_nxt;
      started_r <= started_nxt;
      rate_r    <= rate_nxt;
      wait_r    <= wait_nxt;
      armed_r   <= armed_nxt;
      pend_r    <= pend_nxt;
      lock_r    <= lock_nxt;
    end
  end

  // Output register: load on commit, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_level_r <= lv;
      out_rate_r  <= rate_nxt;
      out_upd_r   <= updated;
      out_shock_r <= fire;
      out_mode_r  <= mode_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign voted_level  = out_level_r;
  assign beat_rate    = out_rate_r;
  assign rate_updated = out_upd_r;
  assign shock        = out_shock_r;
  assign mode         = out_mode_r;

  `RRSC_ASSERT_NEVER(a_arm_pend, clk, rst_n, armed_r && pend_r, "armed and pending at once")
  `RRSC_ASSERT_NEVER(a_runs, clk, rst_n, upper_r != '0 && lower_r != '0, "upper and lower runs both open")
  `RRSC_ASSERT_NEXT(a_rate_hold, clk, rst_n, !(cmd.commit && updated), $stable(rate_r), "rate changed without an update")

endmodule

@@ rtl/redundant_rhythm_shock_controller.sv @@
// Top level of the redundant rhythm shock controller.
`timescale 1ns / 1ps

// Usage:
//  in_ch   one sample tick per transfer: three sensor levels and working flags.
//  out_ch  one result per tick: voted level, last rate, rate flag, shock, mode.
//  cfg_ch  register writes (index 0..7), always ready; write only while idle.
//  A tick is taken into a holding register, checked and then committed
//  into the counters and the output register. A tick that computes a new
//  rate runs a 16-step restoring divider (one quotient bit a cycle)
//  between check and commit.
//  A new tick is taken only after the last one is committed; a tick that
//  runs the divider takes longer than one without a rate.
//  The result waits in the output register while the receiver stalls; the
//  next tick is still taken and held at commit until that register is free.
//  Reset (rst_n low, synchronous) restores register defaults, clears all run
//  counters, timers and the output valid flag.
module redundant_rhythm_shock_controller #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  rrsc_in_if.sink           in_ch,
  rrsc_out_if.source        out_ch,
  rrsc_cfg_if.sink          cfg_ch
);
  import rrsc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Accept every register write
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  rrsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rrsc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .sensor_a_level (in_ch.sensor_a_level),
    .sensor_b_level (in_ch.sensor_b_level),
    .sensor_c_level (in_ch.sensor_c_level),
    .sensor_working (in_ch.sensor_working),
    .cfg_write      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .voted_level    (out_ch.voted_level),
    .beat_rate      (out_ch.beat_rate),
    .rate_updated   (out_ch.rate_updated),
    .shock          (out_ch.shock),
    .mode           (out_ch.mode)
  );

endmodule
